### hdl/spq_pkg.sv
// Shared constants and types of the sorted priority queue.
package spq_pkg;

	localparam int CAPACITY    = 16;
	localparam int DATA_W      = 32;
	localparam int CMD_W       = 2;
	localparam int COUNT_OUT_W = 5;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_FIND   = 2'd2
	} cmd_t;

	// Step commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic compare;
		logic update;
	} ctrl_t;

endpackage

### hdl/spq_ctrl.sv
// Controller state machine that sequences one command through the datapath.
module spq_ctrl
	import spq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	output logic  done,
	output ctrl_t ctrl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_UPDATE,
		ST_REPORT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   compare_q;
	logic   update_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			compare_q <= 1'b0;
			update_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q   <= ST_COMPARE;
						busy_q    <= 1'b1;
						compare_q <= 1'b1;
					end
				end
				ST_COMPARE: begin
					state_q   <= ST_UPDATE;
					compare_q <= 1'b0;
					update_q  <= 1'b1;
				end
				ST_UPDATE: begin
					state_q  <= ST_REPORT;
					update_q <= 1'b0;
					done_q   <= 1'b1;
				end
				ST_REPORT: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b0;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign ctrl.load    = start && !busy_q;
	assign ctrl.compare = compare_q;
	assign ctrl.update  = update_q;

endmodule

### hdl/spq_datapath.sv
// Datapath of the sorted priority queue: a row of entry cells with compare and shift logic.
module spq_datapath
	import spq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_t                    ctrl,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] item_value,
	output logic                     ok,
	output logic [COUNT_OUT_W-1:0]   entry_count,
	output logic                     queue_empty,
	output logic signed [DATA_W-1:0] top_value
);

	cmd_t                     cmd_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] entries_q [CAPACITY];
	logic signed [DATA_W-1:0] next_entry [CAPACITY];
	logic [CNT_W-1:0]         count_q;
	logic                     ok_q;

	logic [CAPACITY-1:0] ge_s1;
	logic [CAPACITY-1:0] le_s1;
	logic                found_s1;
	logic [CAPACITY-1:0] ge_now;
	logic [CAPACITY-1:0] le_now;
	logic [CAPACITY-1:0] eq_now;

	logic full;
	logic do_insert;
	logic do_remove;
	logic ok_next;

	// Entries are descending, so "entry >= value" marks a prefix of the valid cells and
	// "entry <= value" a suffix; when there is an equal entry, the first one opens that suffix.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
		logic valid;
		assign valid     = CNT_W'(i) < count_q;
		assign ge_now[i] = valid && (entries_q[i] >= val_q);
		assign le_now[i] = valid && (entries_q[i] <= val_q);
		assign eq_now[i] = valid && (entries_q[i] == val_q);
	end

	assign full      = count_q >= CNT_W'(CAPACITY);
	assign do_insert = (cmd_q == CMD_INSERT) && !full;
	assign do_remove = (cmd_q == CMD_REMOVE) && found_s1;

	always_comb begin
		unique case (cmd_q)
			CMD_INSERT: ok_next = !full;
			CMD_REMOVE: ok_next = found_s1;
			CMD_FIND:   ok_next = found_s1;
			default:    ok_next = 1'b0;
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] from_above;
		logic signed [DATA_W-1:0] from_below;
		logic                     above_ge;

		if (i == 0) begin : g_head
			assign from_above = val_q;
			assign above_ge   = 1'b1;
		end else begin : g_body
			assign from_above = entries_q[i-1];
			assign above_ge   = ge_s1[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign from_below = entries_q[i];
		end else begin : g_next
			assign from_below = entries_q[i+1];
		end

		always_comb begin
			next_entry[i] = entries_q[i];
			if (do_insert) begin
				if (!ge_s1[i]) begin
					next_entry[i] = above_ge ? val_q : from_above;
				end
			end else if (do_remove) begin
				if (le_s1[i]) begin
					next_entry[i] = from_below;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd_t'(command);
			val_q <= item_value;
		end
		if (ctrl.compare) begin
			ge_s1    <= ge_now;
			le_s1    <= le_now;
			found_s1 <= |eq_now;
		end
		if (ctrl.update) begin
			ok_q <= ok_next;
			for (int i = 0; i < CAPACITY; i++) begin
				entries_q[i] <= next_entry[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.update) begin
			if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_remove) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign ok          = ok_q;
	assign entry_count = COUNT_OUT_W'(count_q);
	assign queue_empty = count_q == '0;
	assign top_value   = (count_q != '0) ? entries_q[0] : '0;

endmodule

### hdl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: controller and datapath.
//
// The queue holds up to CAPACITY signed 32-bit values in descending order.
// A command transfer happens at a rising edge where start is high and busy
// is low; command selects insert, remove of the first equal entry, or find,
// and item_value carries the operand. Equal values keep arrival order.
// Each command yields exactly one result transfer: done is high for one
// cycle while ok, entry_count, queue_empty and top_value describe the
// queue after the command. The receiver cannot hold results off.
// Sequence: the command is taken at the transfer, the cells are compared
// in the next cycle and updated in the one after, and done is then raised
// in the report step. busy stays high from the transfer to the end of the
// done cycle, so a new command is not taken until the previous result has
// been reported; the controller's compare, update and report steps set this.
// An insert into a full queue, or a remove or find with no match, leaves
// the queue unchanged and returns ok low; code 3 does nothing.
// Reset empties the queue at once; no clearing pass is needed because only
// entries below the count are ever looked at.
module sorted_priority_queue_unit
	import spq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	output logic                     done,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] item_value,
	output logic                     ok,
	output logic [COUNT_OUT_W-1:0]   entry_count,
	output logic                     queue_empty,
	output logic signed [DATA_W-1:0] top_value
);

	// Step commands from the controller; the datapath never reports back,
	// since every command goes through the same compare, update and report steps.
	ctrl_t ctrl;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	// The datapath latches the command on transfer, registers the compare
	// flags of every cell, then shifts the cells and updates the count.
	spq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.command     (command),
		.item_value  (item_value),
		.ok          (ok),
		.entry_count (entry_count),
		.queue_empty (queue_empty),
		.top_value   (top_value)
	);

endmodule

### tb/sv/tb_sorted_priority_queue_unit.sv
// Self-checking testbench for the sorted priority queue: directed table, then random phases.
`timescale 1ns / 100ps

module tb_sorted_priority_queue_unit
	import spq_pkg::*;
();

	// Code 3 has no member in the package enum; the block must treat it as a no-op.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFFFFFF;
	localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh80000000;
	// Cycles with no transfer on either side before the run is declared hung.
	localparam int HANG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 175;

	// One result of the queue, as seen on the result ports.
	typedef struct packed {
		logic                     ok;
		logic [COUNT_OUT_W-1:0]   entry_count;
		logic                     queue_empty;
		logic signed [DATA_W-1:0] top_value;
	} outcome_t;

	// One row of the directed table. When fixed is set, want is the result
	// that must appear; otherwise the shadow queue supplies it.
	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] value;
		logic                     fixed;
		outcome_t                 want;
	} plan_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     done;
	logic [CMD_W-1:0]         command;
	logic signed [DATA_W-1:0] item_value;
	logic                     ok;
	logic [COUNT_OUT_W-1:0]   entry_count;
	logic                     queue_empty;
	logic signed [DATA_W-1:0] top_value;

	// Shadow copy of the queue contents, kept in descending order.
	logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
	int                       shadow_count;

	// Results still owed by the block, oldest first.
	outcome_t  pending_outcomes [$];
	plan_row_t plan [$];

	// The driver tags the command it offers, so the monitor knows at the
	// transfer whether a typed-in result goes with it.
	logic     row_fixed;
	outcome_t row_want;

	int idle_pct;
	int mismatches;
	int quiet_cycles;

	sorted_priority_queue_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.command     (command),
		.item_value  (item_value),
		.ok          (ok),
		.entry_count (entry_count),
		.queue_empty (queue_empty),
		.top_value   (top_value)
	);

	always #4 clk = ~clk;

	// Index of the first stored entry equal to v, or the count when none matches.
	function automatic int find_slot(logic signed [DATA_W-1:0] v);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_entries[i] == v)
				return i;
		return shadow_count;
	endfunction

	// Applies one command to the shadow queue and returns the result that the
	// block must report for it. Inserts go behind all entries greater than or
	// equal to the value, so equal values keep their arrival order.
	function automatic outcome_t predict_outcome(logic [CMD_W-1:0] cmd,
			logic signed [DATA_W-1:0] v);
		outcome_t res;
		int       pos;
		res = '0;
		case (cmd)
			CMD_INSERT: begin
				if (shadow_count < CAPACITY) begin
					pos = 0;
					while (pos < shadow_count && shadow_entries[pos] >= v)
						pos++;
					for (int k = shadow_count; k > pos; k--)
						shadow_entries[k] = shadow_entries[k-1];
					shadow_entries[pos] = v;
					shadow_count++;
					res.ok = 1'b1;
				end
			end
			CMD_REMOVE: begin
				pos = find_slot(v);
				if (pos < shadow_count) begin
					for (int k = pos; k + 1 < shadow_count; k++)
						shadow_entries[k] = shadow_entries[k+1];
					shadow_count--;
					res.ok = 1'b1;
				end
			end
			CMD_FIND: res.ok = find_slot(v) < shadow_count;
			default: res.ok = 1'b0;
		endcase
		res.entry_count = COUNT_OUT_W'(shadow_count);
		res.queue_empty = shadow_count == 0;
		res.top_value   = shadow_count > 0 ? shadow_entries[0] : '0;
		return res;
	endfunction

	function automatic void add_row(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] v,
			logic fixed, logic r_ok, int r_count, logic r_empty,
			logic signed [DATA_W-1:0] r_top);
		plan_row_t row;
		row.cmd   = cmd;
		row.value = v;
		row.fixed = fixed;
		row.want  = '{r_ok, COUNT_OUT_W'(r_count), r_empty, r_top};
		plan.push_back(row);
	endfunction

	// Small values in almost half the draws so that duplicates and matches are common, with the
	// extremes and fully random words mixed in to toggle every bit.
	function automatic logic signed [DATA_W-1:0] random_value();
		int r;
		r = $urandom_range(99);
		if (r < 10) begin
			case ($urandom_range(3))
				0: return MAX_VAL;
				1: return MIN_VAL;
				2: return '0;
				default: return -1;
			endcase
		end
		if (r < 55)
			return DATA_W'($urandom_range(15)) - 8;
		return $urandom;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Offers one command, after a random number of idle cycles, and returns at
	// the rising edge where the transfer takes place. start stays high on
	// return, so back-to-back commands need no extra assignment.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] v,
			input logic fixed, input outcome_t want);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start      = 1'b0;
			command    = $urandom;
			item_value = $urandom;
		end
		@(negedge clk);
		start      = 1'b1;
		command    = cmd;
		item_value = v;
		row_fixed  = fixed;
		row_want   = want;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drops start and holds off until every owed result has come back.
	task automatic drain_queue();
		@(negedge clk);
		start = 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Monitor: records each command transfer in the shadow queue and checks
	// each result transfer against the oldest owed result. It also watches
	// for a hang: too many cycles in which neither side moves anything.
	always @(posedge clk) begin : result_check
		outcome_t predicted;
		outcome_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (start && !busy) begin
				predicted = predict_outcome(command, item_value);
				pending_outcomes.push_back(row_fixed ? row_want : predicted);
				quiet_cycles = 0;
			end
			if (done) begin
				quiet_cycles = 0;
				if (pending_outcomes.size() == 0) begin
					report_mismatch("result with no command outstanding");
				end else begin
					want = pending_outcomes.pop_front();
					if (ok !== want.ok)
						report_mismatch($sformatf("ok %b, expected %b", ok, want.ok));
					if (entry_count !== want.entry_count)
						report_mismatch($sformatf("entry_count %0d, expected %0d",
							entry_count, want.entry_count));
					if (queue_empty !== want.queue_empty)
						report_mismatch($sformatf("queue_empty %b, expected %b",
							queue_empty, want.queue_empty));
					if (top_value !== want.top_value)
						report_mismatch($sformatf("top_value %0d, expected %0d",
							top_value, want.top_value));
				end
			end
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("%0t ns: no transfer for %0d cycles", $time, HANG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] v;
		bit                       filling;
		int                       r;
		int                       phase_idle [4];

		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		command      = '0;
		item_value   = '0;
		row_fixed    = 1'b0;
		row_want     = '0;
		idle_pct     = 0;
		mismatches   = 0;
		quiet_cycles = 0;
		shadow_count = 0;
		filling      = 1'b1;
		foreach (shadow_entries[i])
			shadow_entries[i] = '0;

		// Directed table. Rows with a typed-in result cover the empty queue,
		// the extremes of the value range, the unused code and a full queue.
		add_row(CMD_FIND,   0,       1, 0, 0,  1, 0);        // find on empty queue
		add_row(CMD_REMOVE, 5,       1, 0, 0,  1, 0);        // remove on empty queue
		add_row(CMD_UNUSED, 0,       1, 0, 0,  1, 0);        // unused code, empty
		add_row(CMD_INSERT, MAX_VAL, 1, 1, 1,  0, MAX_VAL);
		add_row(CMD_INSERT, MIN_VAL, 1, 1, 2,  0, MAX_VAL);
		add_row(CMD_FIND,   MIN_VAL, 1, 1, 2,  0, MAX_VAL);
		add_row(CMD_REMOVE, MAX_VAL, 1, 1, 1,  0, MIN_VAL);
		add_row(CMD_UNUSED, -1,      1, 0, 1,  0, MIN_VAL);  // unused code, not empty
		// Fill the queue with duplicates and alternating bit patterns.
		add_row(CMD_INSERT, -1,            0, 0, 0, 0, 0);
		add_row(CMD_INSERT, -1,            0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 0,             0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 32'sh55555555, 0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 32'shAAAAAAAA, 0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 0,             0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 7,             0, 0, 0, 0, 0);
		add_row(CMD_INSERT, -7,            0, 0, 0, 0, 0);
		add_row(CMD_INSERT, MAX_VAL,       0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 1,             0, 0, 0, 0, 0);
		add_row(CMD_INSERT, -2,            0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 100,           0, 0, 0, 0, 0);
		add_row(CMD_INSERT, -100,          0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 0,             0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 3,             0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 5,        1, 0, CAPACITY, 0, MAX_VAL);  // insert when full
		add_row(CMD_REMOVE, -1,            0, 0, 0, 0, 0);
		add_row(CMD_FIND,   0,             0, 0, 0, 0, 0);
		add_row(CMD_REMOVE, 32'sh55555555, 0, 0, 0, 0, 0);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i])
			send_item(plan[i].cmd, plan[i].value, plan[i].fixed, plan[i].want);

		// Random phases with different sender gaps. The command mix swings
		// between filling and draining so both a full and an empty queue are
		// reached over and over; removes and finds mostly target stored values.
		phase_idle = '{0, 59, 33, 0};
		foreach (phase_idle[p]) begin
			drain_queue();
			idle_pct = phase_idle[p];
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (shadow_count == 0)
					filling = 1'b1;
				else if (shadow_count == CAPACITY && $urandom_range(3) == 0)
					filling = 1'b0;
				r = $urandom_range(99);
				if (r < 3)
					cmd = CMD_UNUSED;
				else if (r < (filling ? 65 : 30))
					cmd = CMD_INSERT;
				else if ($urandom_range(1) == 0)
					cmd = CMD_REMOVE;
				else
					cmd = CMD_FIND;
				if (cmd != CMD_INSERT && shadow_count > 0 && $urandom_range(99) < 60)
					v = shadow_entries[$urandom_range(shadow_count - 1)];
				else
					v = random_value();
				send_item(cmd, v, 1'b0, '0);
			end
		end

		// Let the last result arrive, then watch a little longer for strays.
		drain_queue();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
